FILE: design/lpc_pkg.sv
package lpc_pkg;

    localparam int DEF_MAX_CENTERS = 256;
    localparam int DEF_COORD_BITS  = 16;

    localparam int NUM_DIMS  = 4;
    localparam int FIELD_W   = 16;
    localparam int ID_W      = 16;
    localparam int THR_W     = 16;
    localparam int DIMS_W    = 3;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 16;
    localparam int LIMIT_W   = 2 * THR_W;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_THRESHOLD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_DIMS      = 1'd1;

    localparam logic [THR_W-1:0]  THRESHOLD_RESET = '0;
    localparam logic [DIMS_W-1:0] DIMS_RESET      = 3'd3;
    localparam logic [DIMS_W-1:0] DIMS_MIN        = 3'd1;
    localparam logic [DIMS_W-1:0] DIMS_MAX        = 3'd4;
    localparam logic [ID_W-1:0]   COUNTER_MAX     = 16'hFFFF;

    typedef struct packed {
        logic load;
        logic issue;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic hit;
        logic scan_end;
        logic pipe_empty;
        logic out_free;
    } t_status;

endpackage

FILE: design/lpc_ctrl.sv
module lpc_ctrl
    import lpc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_tvalid,
    output logic    o_s_tready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_s_tready   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.issue = 1'b1;
                if (i_status.hit || (i_status.scan_end && i_status.pipe_empty)) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                // hold the result until the output register can take it
                if (i_status.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: design/lpc_dpath.sv
module lpc_dpath
    import lpc_pkg::*;
#(
    parameter int MAX_CENTERS = DEF_MAX_CENTERS,
    parameter int COORD_BITS  = DEF_COORD_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_addr,
    input  logic [CFG_W-1:0]           i_cfg_wdata,
    input  logic [NUM_DIMS*FIELD_W-1:0] i_coords,
    input  logic                       i_start_set,
    input  t_cmd                       i_cmd,
    output t_status                    o_status,
    input  logic                       i_m_tready,
    output logic                       o_m_tvalid,
    output logic [ID_W-1:0]            o_cluster_id,
    output logic                       o_is_new_center,
    output logic                       o_overflow
);

    localparam int AW = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;
    localparam int CW = $clog2(MAX_CENTERS + 1);
    localparam int DW = COORD_BITS + 1;
    localparam int QW = 2 * DW;
    localparam int SW = QW + 2;
    localparam int LW = (SW > LIMIT_W) ? SW : LIMIT_W;
    localparam int PW = NUM_DIMS * COORD_BITS;
    localparam logic [CW-1:0] COUNT_FULL = CW'(MAX_CENTERS);

    // configuration
    logic [THR_W-1:0]  r_threshold;
    logic [DIMS_W-1:0] r_cfg_dims;

    // per-item control state
    logic [CW-1:0]   r_count;
    logic [ID_W-1:0] r_counter;
    logic [CW-1:0]   r_addr;
    logic            r_v1;
    logic            r_v2;
    logic            r_hit;
    logic            r_out_valid;

    // per-item payload
    logic [PW-1:0]      r_point;
    logic [ID_W-1:0]    r_idx;
    logic               r_sat;
    logic [DIMS_W-1:0]  r_dims;
    logic [LIMIT_W-1:0] r_limit;
    logic [PW-1:0]      r_rd_coords;
    logic [ID_W-1:0]    r_rd_founder;
    logic [QW-1:0]      r_sq [NUM_DIMS];
    logic [ID_W-1:0]    r_f2;
    logic [ID_W-1:0]    r_hit_id;
    logic [ID_W-1:0]    r_out_id;
    logic               r_out_new;
    logic               r_out_ovf;

    logic [PW-1:0]   mem_coords  [MAX_CENTERS];
    logic [ID_W-1:0] mem_founder [MAX_CENTERS];

    logic [ID_W-1:0]   n_cur;
    logic [DIMS_W-1:0] n_dims;
    logic              w_scan_end;
    logic              w_issue;
    logic              w_full;
    logic              w_store;
    logic signed [DW-1:0] w_diff [NUM_DIMS];
    logic signed [QW-1:0] w_sq   [NUM_DIMS];
    logic [SW-1:0]     w_sum;
    logic              w_match;

    assign n_cur      = i_start_set ? '0 : r_counter;
    assign w_scan_end = (r_addr == r_count);
    assign w_issue    = i_cmd.issue && !w_scan_end && !r_hit;
    assign w_full     = (r_count == COUNT_FULL);
    assign w_store    = !r_hit && !w_full;

    always_comb begin
        if (r_cfg_dims < DIMS_MIN) begin
            n_dims = DIMS_MIN;
        end else if (r_cfg_dims > DIMS_MAX) begin
            n_dims = DIMS_MAX;
        end else begin
            n_dims = r_cfg_dims;
        end
    end

    // one squared term per coordinate, from the point and the center read out
    always_comb begin
        for (int d = 0; d < NUM_DIMS; d++) begin
            w_diff[d] = {r_point[d*COORD_BITS + COORD_BITS - 1],
                         r_point[d*COORD_BITS +: COORD_BITS]}
                      - {r_rd_coords[d*COORD_BITS + COORD_BITS - 1],
                         r_rd_coords[d*COORD_BITS +: COORD_BITS]};
            w_sq[d]   = w_diff[d] * w_diff[d];
        end
    end

    always_comb begin
        w_sum = '0;
        for (int d = 0; d < NUM_DIMS; d++) begin
            w_sum = w_sum + SW'(r_sq[d]);
        end
        w_match = r_v2 && (LW'(w_sum) <= LW'(r_limit));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RESET;
            r_cfg_dims  <= DIMS_RESET;
            r_count     <= '0;
            r_counter   <= '0;
            r_addr      <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we && i_cfg_addr == CFG_IDX_THRESHOLD) begin
                r_threshold <= i_cfg_wdata[THR_W-1:0];
            end
            if (i_cfg_we && i_cfg_addr == CFG_IDX_DIMS) begin
                r_cfg_dims <= i_cfg_wdata[DIMS_W-1:0];
            end
            if (i_cmd.load) begin
                if (i_start_set) begin
                    r_count <= '0;
                end
                r_counter <= (n_cur == COUNTER_MAX) ? n_cur : n_cur + 1'b1;
                r_addr    <= '0;
                r_v1      <= 1'b0;
                r_v2      <= 1'b0;
                r_hit     <= 1'b0;
            end else begin
                if (w_issue) begin
                    r_addr <= r_addr + 1'b1;
                end
                r_v1 <= w_issue;
                r_v2 <= r_v1;
                // keep the first match in storage order
                if (w_match && !r_hit) begin
                    r_hit <= 1'b1;
                end
                if (i_cmd.finish && w_store) begin
                    r_count <= r_count + 1'b1;
                end
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int d = 0; d < NUM_DIMS; d++) begin
                r_point[d*COORD_BITS +: COORD_BITS] <= i_coords[d*FIELD_W +: COORD_BITS];
            end
            r_idx   <= n_cur;
            r_sat   <= (n_cur == COUNTER_MAX);
            r_dims  <= n_dims;
            r_limit <= r_threshold * r_threshold;
        end
        if (w_issue) begin
            r_rd_coords  <= mem_coords[r_addr[AW-1:0]];
            r_rd_founder <= mem_founder[r_addr[AW-1:0]];
        end
        for (int d = 0; d < NUM_DIMS; d++) begin
            r_sq[d] <= (DIMS_W'(d) < r_dims) ? QW'(w_sq[d]) : '0;
        end
        r_f2 <= r_rd_founder;
        if (w_match && !r_hit) begin
            r_hit_id <= r_f2;
        end
        if (i_cmd.finish) begin
            if (w_store) begin
                mem_coords[r_count[AW-1:0]]  <= r_point;
                mem_founder[r_count[AW-1:0]] <= r_idx;
            end
            r_out_id  <= r_hit ? r_hit_id : r_idx;
            r_out_new <= w_store;
            r_out_ovf <= r_sat || (!r_hit && w_full);
        end
    end

    assign o_status.hit        = r_hit;
    assign o_status.scan_end   = w_scan_end;
    assign o_status.pipe_empty = !r_v1 && !r_v2;
    assign o_status.out_free   = !r_out_valid || i_m_tready;

    assign o_m_tvalid      = r_out_valid;
    assign o_cluster_id    = r_out_id;
    assign o_is_new_center = r_out_new;
    assign o_overflow      = r_out_ovf;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_FULL)
        else $error("center count beyond table size");

    a_addr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.load |-> r_addr <= r_count)
        else $error("scan address passed the center count");

    a_hit_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hit && !i_cmd.load |=> r_hit)
        else $error("match flag dropped within an item");

    a_store_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish && w_store |=> r_count == $past(r_count) + 1'b1)
        else $error("new center not counted");
`endif

endmodule

FILE: design/leader_point_clustering.sv
// channel   | dir | handshake           | payload (lowest bit first)
// ----------+-----+---------------------+-----------------------------------------------
// s (point) | in  | i_s_tvalid/o_s_tready | tdata: coord_x, coord_y, coord_z, coord_w; tuser: start_set
// m (label) | out | o_m_tvalid/i_m_tready | tdata: cluster_id; tuser: is_new_center, overflow
// cfg       | in  | i_cfg_we              | i_cfg_addr: 0 threshold, 1 dims_in_use; i_cfg_wdata
//
// One point at a time: the next point is taken only after the last one is finished.
// The scan reads one center per cycle from the table memory through a three-stage
// distance pipe and stops early on the first match.
// Reset (i_rst_n low, synchronous) empties the table and clears the point counter.
// A result waiting on o_m_tvalid does not block taking the next point; only the
// final write-back stalls until the output register frees.
module leader_point_clustering
    import lpc_pkg::*;
#(
    parameter int MAX_CENTERS = DEF_MAX_CENTERS,
    parameter int COORD_BITS  = DEF_COORD_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_addr,
    input  logic [CFG_W-1:0]            i_cfg_wdata,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [NUM_DIMS*FIELD_W-1:0] i_s_tdata,  // coord_x, coord_y, coord_z, coord_w
    input  logic                        i_s_tuser,  // start_set
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [ID_W-1:0]             o_m_tdata,  // cluster_id
    output logic [1:0]                  o_m_tuser   // is_new_center, overflow
);

    t_cmd    w_cmd;
    t_status w_status;
    logic    w_is_new;
    logic    w_ovf;

    lpc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    lpc_dpath #(
        .MAX_CENTERS (MAX_CENTERS),
        .COORD_BITS  (COORD_BITS)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_coords        (i_s_tdata),
        .i_start_set     (i_s_tuser),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .i_m_tready      (i_m_tready),
        .o_m_tvalid      (o_m_tvalid),
        .o_cluster_id    (o_m_tdata),
        .o_is_new_center (w_is_new),
        .o_overflow      (w_ovf)
    );

    assign o_m_tuser = {w_ovf, w_is_new};

endmodule

FILE: tb/leader_point_clustering_test.sv
`timescale 1ns / 1ps

module leader_point_clustering_test;
    import lpc_pkg::*;

    localparam int MAX_CENTERS    = DEF_MAX_CENTERS;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = MAX_CENTERS + 40;
    localparam int PRINT_LIMIT    = 40;
    localparam int LABEL_DEPTH    = 16;
    localparam int RANDOM_PHASES  = 7;

    typedef logic [NUM_DIMS-1:0][FIELD_W-1:0] t_coords;

    typedef struct packed {
        logic    start;
        t_coords coords;
    } t_point;

    typedef struct packed {
        logic [ID_W-1:0] cluster_id;
        logic            is_new_center;
        logic            overflow;
    } t_label;

    logic                        i_clk       = 1'b0;
    logic                        i_rst_n     = 1'b0;
    logic                        i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]        i_cfg_addr  = '0;
    logic [CFG_W-1:0]            i_cfg_wdata = '0;
    logic                        i_s_tvalid  = 1'b0;
    logic                        o_s_tready;
    logic [NUM_DIMS*FIELD_W-1:0] i_s_tdata   = '0;  // coord_x, coord_y, coord_z, coord_w
    logic                        i_s_tuser   = 1'b0; // start_set
    logic                        o_m_tvalid;
    logic                        i_m_tready  = 1'b0;
    logic [ID_W-1:0]             o_m_tdata;          // cluster_id
    logic [1:0]                  o_m_tuser;          // is_new_center, overflow

    // clustering state as the block should hold it
    t_coords           center_coords [MAX_CENTERS];
    logic [ID_W-1:0]   center_founder [MAX_CENTERS];
    int                center_total = 0;
    int                next_index   = 0;
    logic [THR_W-1:0]  radius       = THRESHOLD_RESET;
    logic [DIMS_W-1:0] dims_reg     = DIMS_RESET;

    // labels still owed by the block, oldest at the head
    t_label expected_labels [LABEL_DEPTH];
    int     expected_head  = 0;
    int     expected_tail  = 0;
    int     mismatch_count = 0;
    int     quiet_cycles   = 0;
    int     stall_left     = 0;
    bit     bursty         = 1'b1;

    leader_point_clustering dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    always #4 i_clk = ~i_clk;

    function automatic longint distance_sq(t_coords a, t_coords b, int dims);
        longint sum = 0;
        longint diff;
        for (int d = 0; d < dims; d++) begin
            diff = longint'($signed(a[d])) - longint'($signed(b[d]));
            sum += diff * diff;
        end
        return sum;
    endfunction

    function automatic t_label classify_point(t_point p);
        t_label lbl;
        int     dims;
        int     idx;
        longint limit;
        bit     hit;
        lbl = '0;
        hit = 1'b0;
        if (p.start) begin
            center_total = 0;
            next_index   = 0;
        end
        // clamp the dimension count into 1..4
        dims = int'(dims_reg);
        if (dims < int'(DIMS_MIN)) dims = int'(DIMS_MIN);
        if (dims > int'(DIMS_MAX)) dims = int'(DIMS_MAX);
        idx = next_index;
        if (next_index >= int'(COUNTER_MAX))
            lbl.overflow = 1'b1;
        else
            next_index++;
        limit = longint'(radius) * longint'(radius);
        for (int c = 0; c < center_total && !hit; c++) begin
            if (distance_sq(p.coords, center_coords[c], dims) <= limit) begin
                lbl.cluster_id = center_founder[c];
                hit = 1'b1;
            end
        end
        if (!hit) begin
            lbl.cluster_id = idx[ID_W-1:0];
            if (center_total < MAX_CENTERS) begin
                center_coords[center_total]  = p.coords;
                center_founder[center_total] = idx[ID_W-1:0];
                center_total++;
                lbl.is_new_center = 1'b1;
            end else begin
                lbl.overflow = 1'b1;
            end
        end
        return lbl;
    endfunction

    function automatic t_point make_point(logic start, int x, int y, int z, int w);
        t_point p;
        p.start     = start;
        p.coords[0] = x[FIELD_W-1:0];
        p.coords[1] = y[FIELD_W-1:0];
        p.coords[2] = z[FIELD_W-1:0];
        p.coords[3] = w[FIELD_W-1:0];
        return p;
    endfunction

    function automatic t_coords random_coords();
        t_coords c;
        for (int d = 0; d < NUM_DIMS; d++)
            c[d] = 16'($urandom);
        return c;
    endfunction

    // scatter around a seed; offsets past the coordinate range wrap
    function automatic t_coords near_coords(t_coords seed, int spread);
        t_coords c;
        int      off;
        for (int d = 0; d < NUM_DIMS; d++) begin
            off  = int'($urandom_range(0, 2 * spread)) - spread;
            c[d] = 16'(int'($signed(seed[d])) + off);
        end
        return c;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        mismatch_count++;
        // hold the log to a readable size
        if (mismatch_count <= PRINT_LIMIT)
            $display("%0t: %s mismatch: got %0d, want %0d", $time, what, got, want);
    endtask

    task automatic send_point(t_point p);
        @(negedge i_clk);
        if (bursty && $urandom_range(0, 4) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= p.coords;
        i_s_tuser  <= p.start;
        do @(posedge i_clk); while (!o_s_tready);
        expected_labels[expected_tail % LABEL_DEPTH] = classify_point(p);
        expected_tail++;
    endtask

    task automatic stop_points();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (expected_tail != expected_head)
            @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_IDX_THRESHOLD)
            radius = value[THR_W-1:0];
        else
            dims_reg = value[DIMS_W-1:0];
    endtask

    // write both registers once the block has gone quiet
    task automatic configure(logic [CFG_W-1:0] thr, logic [CFG_W-1:0] dims_word);
        stop_points();
        wait_drained();
        write_reg(CFG_IDX_THRESHOLD, thr);
        write_reg(CFG_IDX_DIMS, dims_word);
    endtask

    task automatic test_reset_config();
        send_point(make_point(1'b1, 0, 0, 0, 0));
        send_point(make_point(1'b0, -32768, -32768, -32768, -32768));
        send_point(make_point(1'b0, 32767, 32767, 32767, 32767));
        send_point(make_point(1'b0, 0, 0, 0, 7));
        send_point(make_point(1'b0, -32768, -32768, -32768, 32767));
    endtask

    task automatic test_radius_boundary();
        configure(16'd5, 16'd2);
        send_point(make_point(1'b1, 0, 0, 0, 0));
        send_point(make_point(1'b0, 5, 0, 0, 0));
        send_point(make_point(1'b0, 3, -4, 9, 9));
        send_point(make_point(1'b0, 4, 4, 0, 0));
        send_point(make_point(1'b0, -6, 0, 0, 0));
        send_point(make_point(1'b0, 0, 6, 0, 0));
    endtask

    task automatic test_dims_clamp();
        configure(16'hFFFF, 16'd0);
        send_point(make_point(1'b1, -32768, 5, 5, 5));
        send_point(make_point(1'b0, 32767, -32768, 0, 0));
        configure(16'hFFFF, 16'd7);
        send_point(make_point(1'b0, 32767, 32767, 32767, 32767));
        send_point(make_point(1'b0, -32768, -32768, -32768, -32768));
        configure(16'd1, 16'd5);
        send_point(make_point(1'b1, 1, 1, 1, 1));
        send_point(make_point(1'b0, 0, 1, 1, 1));
        send_point(make_point(1'b0, 0, 0, 1, 1));
        send_point(make_point(1'b0, 1, 1, 1, 0));
    endtask

    task automatic test_table_full();
        t_point  p;
        t_coords kept;
        t_coords rnd;
        configure(16'd0, 16'd4);
        for (int i = 0; i < MAX_CENTERS; i++) begin
            p = make_point(i == 0, i - 128, 0, 0, 0);
            rnd = random_coords();
            p.coords[3:1] = rnd[3:1];
            if (i == 37)
                kept = p.coords;
            send_point(p);
        end
        // full table: no match, so flag and drop
        for (int i = 0; i < 3; i++) begin
            p = make_point(1'b0, 200 + i, 0, 0, 0);
            rnd = random_coords();
            p.coords[3:1] = rnd[3:1];
            send_point(p);
        end
        p.start  = 1'b0;
        p.coords = kept;
        send_point(p);
        p.start = 1'b1;
        send_point(p);
    endtask

    task automatic test_random_clusters();
        t_coords          seeds [8];
        int               n_seeds;
        int               pick;
        int               spread;
        logic [THR_W-1:0] thr;
        t_point           p;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            // run the last phase with no idling on either side
            bursty = (phase < RANDOM_PHASES - 1);
            case ($urandom_range(0, 4))
                0:       thr = '0;
                1:       thr = '1;
                2:       thr = 16'($urandom_range(1, 16));
                3:       thr = 16'($urandom_range(17, 3000));
                default: thr = 16'($urandom);
            endcase
            configure(thr, 16'($urandom));
            n_seeds = $urandom_range(1, 8);
            for (int s = 0; s < n_seeds; s++)
                seeds[s] = random_coords();
            for (int i = 0; i < 100; i++) begin
                p.start = (i == 0) || ($urandom_range(0, 39) == 0);
                pick    = $urandom_range(0, 9);
                if (pick < 8) begin
                    // mostly inside the radius, some straddling it
                    spread   = (pick < 5) ? int'(thr) / 2 : 2 * int'(thr) + 1;
                    p.coords = near_coords(seeds[$urandom_range(0, n_seeds - 1)], spread);
                end else begin
                    p.coords = random_coords();
                end
                send_point(p);
            end
        end
    endtask

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_m_tready <= 1'b0;
        end else if (bursty && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 3);
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : check_labels
        t_label want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_head == expected_tail) begin
                report_mismatch("unexpected label, cluster_id", int'(o_m_tdata), -1);
            end else begin
                want = expected_labels[expected_head % LABEL_DEPTH];
                expected_head++;
                if (o_m_tdata !== want.cluster_id)
                    report_mismatch("cluster_id", int'(o_m_tdata), int'(want.cluster_id));
                if (o_m_tuser[0] !== want.is_new_center)
                    report_mismatch("is_new_center", int'(o_m_tuser[0]),
                                    int'(want.is_new_center));
                if (o_m_tuser[1] !== want.overflow)
                    report_mismatch("overflow", int'(o_m_tuser[1]), int'(want.overflow));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("leader_point_clustering test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_config();
        test_radius_boundary();
        test_dims_clamp();
        test_table_full();
        test_random_clusters();
        stop_points();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("leader_point_clustering test passed");
        else
            $display("leader_point_clustering test failed");
        $finish;
    end

endmodule
